>>> rtl/kvif_pkg.sv
// Shared types and constants for the key=value integer field extractor.
package kvif_pkg;

  localparam int unsigned MaxNameBytes = 8;
  localparam int unsigned ValueBits    = 32;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned FieldValueW  = 32;

  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharEqual = 8'h3d;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [3:0] Radix     = 4'd10;

  typedef enum logic [1:0] {
    CFG_FIELD_NAME     = 2'd0,
    CFG_FIELD_NAME_LEN = 2'd1,
    CFG_USE_FALLBACK   = 2'd2,
    CFG_FALLBACK_VALUE = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DEFAULTED = 3'd1,
    ST_MISSING   = 3'd2,
    ST_BAD       = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CLS_COMMA,
    CLS_EQUAL,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_e;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       has_byte;
    logic       record_end;
  } item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [FieldValueW-1:0] field_value;
  } result_t;

  // Classified byte as handed from the front to the back
  typedef struct packed {
    logic [7:0]  record_byte;
    char_class_e cls;
    logic [3:0]  digit;
    logic        has_byte;
    logic        record_end;
  } token_t;

  typedef struct packed {
    logic [CfgDataW-1:0]           field_name;
    logic [3:0]                    field_name_length;
    logic                          use_fallback;
    logic signed [FieldValueW-1:0] fallback_value;
  } cfg_t;

endpackage

>>> rtl/kvif_front.sv
// Front end: classifies each incoming record byte for the parser.
module kvif_front (
  input  kvif_pkg::item_t  item_i,
  output kvif_pkg::token_t tok_o
);

  logic [7:0] digit_full;

  assign digit_full = item_i.record_byte - kvif_pkg::CharZero;

  always_comb begin
    tok_o.record_byte = item_i.record_byte;
    tok_o.has_byte    = item_i.has_byte;
    tok_o.record_end  = item_i.record_end;
    tok_o.digit       = digit_full[3:0];
    if (item_i.record_byte == kvif_pkg::CharComma) begin
      tok_o.cls = kvif_pkg::CLS_COMMA;
    end else if (item_i.record_byte == kvif_pkg::CharEqual) begin
      tok_o.cls = kvif_pkg::CLS_EQUAL;
    end else if (item_i.record_byte == kvif_pkg::CharMinus) begin
      tok_o.cls = kvif_pkg::CLS_MINUS;
    end else if (item_i.record_byte >= kvif_pkg::CharZero &&
                 item_i.record_byte <= kvif_pkg::CharNine) begin
      tok_o.cls = kvif_pkg::CLS_DIGIT;
    end else begin
      tok_o.cls = kvif_pkg::CLS_OTHER;
    end
  end

endmodule

>>> rtl/kvif_fifo.sv
// Small register-based queue used between the stages and at the output.
module kvif_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = kvif_pkg::QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/kvif_back.sv
// Back end: key match and integer value parse, one token per cycle unless stalled.
module kvif_back #(
  parameter int unsigned MAX_NAME_BYTES = kvif_pkg::MaxNameBytes,
  parameter int unsigned VALUE_BITS     = kvif_pkg::ValueBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kvif_pkg::cfg_t    cfg_i,
  input  kvif_pkg::token_t  tok_i,
  input  logic              tok_valid_i,
  output logic              tok_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output kvif_pkg::result_t res_o
);

  localparam int unsigned PosW  = $clog2(MAX_NAME_BYTES + 1);
  localparam int unsigned IdxW  = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
  localparam int unsigned MagW  = VALUE_BITS;
  localparam int unsigned ProdW = VALUE_BITS + 4;
  localparam int unsigned ValW  = kvif_pkg::FieldValueW;

  typedef enum logic [1:0] {
    PH_KEY,
    PH_VALUE,
    PH_SKIP,
    PH_DONE
  } phase_e;

  typedef struct packed {
    kvif_pkg::status_e status;
    logic [ValW-1:0]   value;
  } fin_t;

  function automatic fin_t finish_value(logic inv, logic dg, logic ov, logic mn,
                                        logic [MagW-1:0] m);
    fin_t            f;
    logic [MagW-1:0] v;
    v = mn ? (MagW'(0) - m) : m;
    if (inv || !dg) begin
      f.status = kvif_pkg::ST_BAD;
      f.value  = '0;
    end else if (ov) begin
      f.status = kvif_pkg::ST_OVERFLOW;
      f.value  = '0;
    end else begin
      f.status = kvif_pkg::ST_OK;
      f.value  = ValW'(signed'(v));
    end
    return f;
  endfunction

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              km_q, km_d;
  logic [MagW-1:0]   mag_q, mag_d;
  logic              minus_q, minus_d;
  logic              started_q, started_d;
  logic              digit_q, digit_d;
  logic              inv_q, inv_d;
  logic              ovf_q, ovf_d;
  kvif_pkg::status_e lst_q, lst_d;
  logic [ValW-1:0]   lval_q, lval_d;

  logic [PosW-1:0]   name_len;
  logic [7:0]        name_bytes [2**IdxW];
  logic [7:0]        pos_byte;
  logic [ProdW-1:0]  prod, limit;
  fin_t              fin;

  assign tok_pop_o = tok_valid_i && !res_full_i;

  always_comb begin
    if (cfg_i.field_name_length > 4'(MAX_NAME_BYTES)) begin
      name_len = PosW'(MAX_NAME_BYTES);
    end else begin
      name_len = PosW'(cfg_i.field_name_length);
    end
    for (int i = 0; i < 2**IdxW; i++) begin
      name_bytes[i] = cfg_i.field_name[8*i +: 8];
    end
  end

  assign pos_byte = name_bytes[pos_q[IdxW-1:0]];

  // 10*m + d against the signed limit; same test as m > (limit - d) / 10
  assign prod  = (ProdW'(mag_q) << 3) + (ProdW'(mag_q) << 1) + ProdW'(tok_i.digit);
  assign limit = (ProdW'(1) << (VALUE_BITS - 1)) - (minus_q ? ProdW'(0) : ProdW'(1));

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    km_d      = km_q;
    mag_d     = mag_q;
    minus_d   = minus_q;
    started_d = started_q;
    digit_d   = digit_q;
    inv_d     = inv_q;
    ovf_d     = ovf_q;
    lst_d     = lst_q;
    lval_d    = lval_q;
    res_push_o        = 1'b0;
    res_o.status      = kvif_pkg::ST_MISSING;
    res_o.field_value = '0;
    fin = finish_value(inv_q, digit_q, ovf_q, minus_q, mag_q);

    if (tok_pop_o && tok_i.has_byte) begin
      case (phase_q)
        PH_KEY: begin
          if (tok_i.cls == kvif_pkg::CLS_COMMA) begin
            pos_d = '0;
            km_d  = 1'b1;
          end else if (tok_i.cls == kvif_pkg::CLS_EQUAL) begin
            if (km_q && pos_q == name_len) begin
              phase_d   = PH_VALUE;
              mag_d     = '0;
              minus_d   = 1'b0;
              started_d = 1'b0;
              digit_d   = 1'b0;
              inv_d     = 1'b0;
              ovf_d     = 1'b0;
            end else begin
              phase_d = PH_SKIP;
            end
          end else if (km_q && pos_q < name_len && tok_i.record_byte == pos_byte) begin
            pos_d = pos_q + 1'b1;
          end else begin
            km_d = 1'b0;
          end
        end
        PH_SKIP: begin
          if (tok_i.cls == kvif_pkg::CLS_COMMA) begin
            pos_d   = '0;
            km_d    = 1'b1;
            phase_d = PH_KEY;
          end
        end
        PH_VALUE: begin
          if (tok_i.cls == kvif_pkg::CLS_COMMA) begin
            lst_d   = fin.status;
            lval_d  = fin.value;
            phase_d = PH_DONE;
          end else begin
            if (tok_i.cls == kvif_pkg::CLS_MINUS && !started_q) begin
              minus_d = 1'b1;
            end else if (tok_i.cls == kvif_pkg::CLS_DIGIT) begin
              digit_d = 1'b1;
              if (!ovf_q) begin
                if (prod > limit) begin
                  ovf_d = 1'b1;
                end else begin
                  mag_d = prod[MagW-1:0];
                end
              end
            end else begin
              inv_d = 1'b1;
            end
            started_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (tok_pop_o && tok_i.record_end) begin
      res_push_o = 1'b1;
      if (phase_d == PH_VALUE) begin
        // record ended inside the value: close it with the updated flags
        fin     = finish_value(inv_d, digit_d, ovf_d, minus_d, mag_d);
        lst_d   = fin.status;
        lval_d  = fin.value;
        phase_d = PH_DONE;
      end
      if (phase_d == PH_DONE) begin
        res_o.status      = lst_d;
        res_o.field_value = signed'(lval_d);
      end else if (cfg_i.use_fallback) begin
        res_o.status      = kvif_pkg::ST_DEFAULTED;
        res_o.field_value = cfg_i.fallback_value;
      end else begin
        res_o.status      = kvif_pkg::ST_MISSING;
        res_o.field_value = '0;
      end
      phase_d   = PH_KEY;
      pos_d     = '0;
      km_d      = 1'b1;
      mag_d     = '0;
      minus_d   = 1'b0;
      started_d = 1'b0;
      digit_d   = 1'b0;
      inv_d     = 1'b0;
      ovf_d     = 1'b0;
      lst_d     = kvif_pkg::ST_MISSING;
      lval_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_KEY;
      pos_q     <= '0;
      km_q      <= 1'b1;
      mag_q     <= '0;
      minus_q   <= 1'b0;
      started_q <= 1'b0;
      digit_q   <= 1'b0;
      inv_q     <= 1'b0;
      ovf_q     <= 1'b0;
      lst_q     <= kvif_pkg::ST_MISSING;
      lval_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      km_q      <= km_d;
      mag_q     <= mag_d;
      minus_q   <= minus_d;
      started_q <= started_d;
      digit_q   <= digit_d;
      inv_q     <= inv_d;
      ovf_q     <= ovf_d;
      lst_q     <= lst_d;
      lval_q    <= lval_d;
    end
  end

endmodule

>>> rtl/key_value_integer_field_extract.sv
// Top level of the key=value integer field extractor.
//
// Record bytes come in on a queue-style port: an item transfers when push is
// high and full is low. Each item carries record_byte, has_byte and
// record_end. Results leave on a second queue-style port: the oldest result
// sits on result_o while empty is low and transfers when pop is high.
// One result (status and field_value) follows each item with record_end set.
// Configuration (field name, name length, fallback enable, fallback value)
// is written through cfg_valid_i/cfg_ready_o with cfg_index_i selecting the
// register; ready is always high, and writes belong in idle periods.
// An item that transfers is written into the front queue; the parser then takes
// it from that queue and pushes any result it makes into the result queue.
// Throughput: one item per cycle while the result queue has room.
// A stalled receiver fills the two-entry result queue, the parser then holds,
// the front queue fills and full rises; nothing is dropped.
// Reset clears the parse state, the queues and the configuration registers.
module key_value_integer_field_extract #(
  parameter int unsigned MAX_NAME_BYTES = kvif_pkg::MaxNameBytes,
  parameter int unsigned VALUE_BITS     = kvif_pkg::ValueBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  kvif_pkg::item_t               item_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output kvif_pkg::result_t             result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [kvif_pkg::CfgDataW-1:0] cfg_data_i
);

  kvif_pkg::cfg_t    cfg_q;
  kvif_pkg::token_t  tok_in, tok_out;
  kvif_pkg::result_t res;
  logic              tok_empty, tok_pop, res_full, res_push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        kvif_pkg::CFG_FIELD_NAME:     cfg_q.field_name        <= cfg_data_i;
        kvif_pkg::CFG_FIELD_NAME_LEN: cfg_q.field_name_length <= cfg_data_i[3:0];
        kvif_pkg::CFG_USE_FALLBACK:   cfg_q.use_fallback      <= cfg_data_i[0];
        kvif_pkg::CFG_FALLBACK_VALUE: begin
          cfg_q.fallback_value <= signed'(cfg_data_i[kvif_pkg::FieldValueW-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  kvif_front u_front (
    .item_i (item_i),
    .tok_o  (tok_in)
  );

  kvif_fifo #(
    .T     (kvif_pkg::token_t),
    .DEPTH (kvif_pkg::QueueDepth)
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (tok_in),
    .full_o  (full),
    .pop_i   (tok_pop),
    .data_o  (tok_out),
    .empty_o (tok_empty)
  );

  kvif_back #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES),
    .VALUE_BITS     (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tok_i       (tok_out),
    .tok_valid_i (!tok_empty),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  kvif_fifo #(
    .T     (kvif_pkg::result_t),
    .DEPTH (kvif_pkg::QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

  // a result is produced exactly when a record-ending token is consumed
  a_result_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push == (tok_pop && tok_out.record_end))
    else $error("result push without record end");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("parser wrote a full result queue");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> result_o.status <= kvif_pkg::ST_OVERFLOW)
    else $error("result status out of range");

  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.status == kvif_pkg::ST_MISSING ||
                result_o.status == kvif_pkg::ST_BAD ||
                result_o.status == kvif_pkg::ST_OVERFLOW)) |-> result_o.field_value == 0)
    else $error("nonzero value on failing status");

endmodule
